// File: rtl/core/hdtp_pkg.sv
// Shared types, constants and lookup functions for the HTTP date text parser.
// No dependencies; every other file of the block refers to it by scoped names.
package hdtp_pkg;

    typedef enum logic [1:0] {
        FMT_1123 = 2'd0,
        FMT_850  = 2'd1,
        FMT_ASC  = 2'd2
    } hdtp_fmt_t;

    typedef enum logic [2:0] {
        ROLE_DAY,
        ROLE_MON,
        ROLE_YEAR,
        ROLE_HOUR,
        ROLE_MIN,
        ROLE_SEC
    } hdtp_role_t;

    localparam int unsigned POS_W       = 6;
    localparam int unsigned YEAR_W      = 14;
    localparam int unsigned SMALL_W     = 7;
    localparam int unsigned MONTH_W     = 4;
    localparam logic [POS_W-1:0] POS_MAX     = 6'd63;
    localparam logic [POS_W-1:0] POS_FORMAT  = 6'd3;
    localparam logic [POS_W-1:0] POS_ASC_START = 6'd4;
    localparam logic [POS_W-1:0] POS_FIELDS  = 6'd5;
    localparam logic [POS_W-1:0] MIN_LEN     = 6'd23;
    localparam logic [2:0]       FIELD_COUNT = 3'd6;
    localparam logic [2:0]       LAST_FIELD  = 3'd5;
    localparam logic [MONTH_W-1:0] NO_MONTH  = 4'd12;
    localparam logic [YEAR_W-1:0] YEAR_BASE_850 = 14'd1900;
    localparam logic [7:0]       CHAR_COMMA  = 8'h2C;

    // Month names in lower case, first letter in the top byte.
    localparam logic [23:0] MONTH_NAMES [12] = '{
        24'h6A616E, 24'h666562, 24'h6D6172, 24'h617072,
        24'h6D6179, 24'h6A756E, 24'h6A756C, 24'h617567,
        24'h736570, 24'h6F6374, 24'h6E6F76, 24'h646563
    };

    // One classified input byte as it travels from the front end to the back end.
    typedef struct packed {
        logic [7:0]       char_byte;
        logic             last_byte;
        logic [POS_W-1:0] pos;
        logic             is_digit;
        logic             is_space;
        logic             is_comma;
    } hdtp_item_t;

    typedef struct packed {
        logic                 valid_res;
        logic [1:0]           date_format;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [SMALL_W-1:0]   day_of_month;
        logic [SMALL_W-1:0]   hour;
        logic [SMALL_W-1:0]   minute;
        logic [SMALL_W-1:0]   second;
    } hdtp_result_t;

    function automatic hdtp_role_t role_of(input hdtp_fmt_t fmt, input logic [2:0] fidx);
        hdtp_role_t r;
        if (fmt == FMT_ASC) begin
            case (fidx)
                3'd0:    r = ROLE_MON;
                3'd1:    r = ROLE_DAY;
                3'd2:    r = ROLE_HOUR;
                3'd3:    r = ROLE_MIN;
                3'd4:    r = ROLE_SEC;
                default: r = ROLE_YEAR;
            endcase
        end else begin
            case (fidx)
                3'd0:    r = ROLE_DAY;
                3'd1:    r = ROLE_MON;
                3'd2:    r = ROLE_YEAR;
                3'd3:    r = ROLE_HOUR;
                3'd4:    r = ROLE_MIN;
                default: r = ROLE_SEC;
            endcase
        end
        return r;
    endfunction

    // The first letter matches in either case, the other two in lower case only.
    function automatic logic [MONTH_W-1:0] month_lookup(input logic [23:0] letters);
        logic [MONTH_W-1:0] idx;
        logic [23:0]        key;
        idx = NO_MONTH;
        key = letters | 24'h200000;
        for (int i = 11; i >= 0; i--) begin
            if (key == MONTH_NAMES[i]) begin
                idx = MONTH_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/hdtp_front.sv
// Front end of the HTTP date text parser: accepts bytes, tracks the position in
// the string and classifies each byte before it enters the queue. Uses hdtp_pkg.
module hdtp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,    // char_byte
    input  logic                s_tlast,    // last_byte
    input  logic                queue_full,
    output logic                push,
    output hdtp_pkg::hdtp_item_t push_item
);

    logic [hdtp_pkg::POS_W-1:0] pos_reg;
    logic [hdtp_pkg::POS_W-1:0] pos_next;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_item.char_byte = s_tdata;
        push_item.last_byte = s_tlast;
        push_item.pos       = pos_reg;
        push_item.is_digit  = (s_tdata inside {[8'h30:8'h39]});
        push_item.is_space  = (s_tdata inside {8'h20, [8'h09:8'h0D]});
        push_item.is_comma  = (s_tdata == hdtp_pkg::CHAR_COMMA);

        pos_next = pos_reg;
        if (push) begin
            if (s_tlast) begin
                pos_next = '0;
            end else if (pos_reg != hdtp_pkg::POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: rtl/core/hdtp_queue.sv
// Short queue of classified bytes between the front and back ends of the parser.
// Uses hdtp_pkg for the item type.
module hdtp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hdtp_pkg::hdtp_item_t push_item,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output hdtp_pkg::hdtp_item_t head_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hdtp_pkg::hdtp_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_pop_only_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on a pop");

endmodule

// File: rtl/core/hdtp_back.sv
// Back end of the HTTP date text parser: walks the fields of the string, gathers
// digits and month letters, and holds the finished result. Uses hdtp_pkg.
module hdtp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  hdtp_pkg::hdtp_item_t   item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hdtp_pkg::hdtp_result_t out_result
);

    localparam int unsigned YW = hdtp_pkg::YEAR_W;
    localparam int unsigned SW = hdtp_pkg::SMALL_W;

    hdtp_pkg::hdtp_fmt_t fmt_reg, fmt_next;
    logic          skip_reg, skip_next;
    logic [2:0]    fidx_reg, fidx_next;
    logic [2:0]    dcnt_reg, dcnt_next;
    logic [23:0]   mon_reg, mon_next;
    logic [SW-1:0] day_reg, day_next;
    logic [YW-1:0] year_reg, year_next;
    logic [SW-1:0] hour_reg, hour_next;
    logic [SW-1:0] min_reg, min_next;
    logic [SW-1:0] sec_reg, sec_next;
    logic          err_reg, err_next;

    logic                   out_valid_reg;
    hdtp_pkg::hdtp_result_t out_result_reg, result_next;

    logic                 field_en;
    logic                 acc_en;
    hdtp_pkg::hdtp_role_t role;
    logic [2:0]           datalen;
    logic [2:0]           total;
    logic [2:0]           dcnt_inc;
    logic [YW-1:0]        acc_sel;
    logic [YW+3:0]        acc_prod;
    logic [YW-1:0]        acc_new;
    logic [hdtp_pkg::MONTH_W-1:0] mon_idx;
    logic                 ok;

    assign pop        = item_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    always_comb begin
        fmt_next  = fmt_reg;
        skip_next = skip_reg;
        fidx_next = fidx_reg;
        dcnt_next = dcnt_reg;
        mon_next  = mon_reg;
        day_next  = day_reg;
        year_next = year_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        err_next  = err_reg;
        field_en  = 1'b0;
        acc_en    = 1'b0;

        if (item.pos == hdtp_pkg::POS_FORMAT) begin
            if (item.is_comma) begin
                fmt_next = hdtp_pkg::FMT_1123;
            end else if (item.is_space) begin
                fmt_next = hdtp_pkg::FMT_ASC;
            end else begin
                fmt_next  = hdtp_pkg::FMT_850;
                skip_next = 1'b1;
            end
        end else if (item.pos == hdtp_pkg::POS_ASC_START) begin
            field_en = (fmt_reg == hdtp_pkg::FMT_ASC);
        end else if (item.pos >= hdtp_pkg::POS_FIELDS) begin
            // RFC 850 skips its spelled-out weekday up to the first digit.
            if (skip_reg) begin
                if (item.is_digit) begin
                    skip_next = 1'b0;
                    field_en  = 1'b1;
                end
            end else begin
                field_en = 1'b1;
            end
        end

        role = hdtp_pkg::role_of(fmt_reg, fidx_reg);
        if (role == hdtp_pkg::ROLE_MON) begin
            datalen = 3'd3;
        end else if (role == hdtp_pkg::ROLE_YEAR && fmt_reg != hdtp_pkg::FMT_850) begin
            datalen = 3'd4;
        end else begin
            datalen = 3'd2;
        end
        total    = datalen + ((fidx_reg < hdtp_pkg::LAST_FIELD) ? 3'd1 : 3'd0);
        dcnt_inc = dcnt_reg + 1'b1;

        case (role)
            hdtp_pkg::ROLE_DAY:  acc_sel = YW'(day_reg);
            hdtp_pkg::ROLE_YEAR: acc_sel = year_reg;
            hdtp_pkg::ROLE_HOUR: acc_sel = YW'(hour_reg);
            hdtp_pkg::ROLE_MIN:  acc_sel = YW'(min_reg);
            hdtp_pkg::ROLE_SEC:  acc_sel = YW'(sec_reg);
            default:             acc_sel = '0;
        endcase
        acc_prod = ((YW+4)'(acc_sel) * (YW+4)'(10)) + (YW+4)'(item.char_byte[3:0]);
        acc_new  = acc_prod[YW-1:0];

        if (field_en && fidx_reg < hdtp_pkg::FIELD_COUNT) begin
            if (dcnt_reg < datalen) begin
                case (role)
                    hdtp_pkg::ROLE_MON: begin
                        mon_next = {mon_reg[15:0], item.char_byte};
                    end
                    hdtp_pkg::ROLE_DAY: begin
                        // A one-digit asctime day has a leading byte that is skipped.
                        acc_en = !(fmt_reg == hdtp_pkg::FMT_ASC && dcnt_reg == 3'd0
                                   && !item.is_digit);
                    end
                    default: begin
                        acc_en = 1'b1;
                    end
                endcase
            end
            if (dcnt_inc >= total) begin
                dcnt_next = '0;
                fidx_next = fidx_reg + 1'b1;
            end else begin
                dcnt_next = dcnt_inc;
            end
        end

        if (acc_en) begin
            if (!item.is_digit) begin
                err_next = 1'b1;
            end else begin
                case (role)
                    hdtp_pkg::ROLE_DAY:  day_next  = acc_new[SW-1:0];
                    hdtp_pkg::ROLE_YEAR: year_next = acc_new;
                    hdtp_pkg::ROLE_HOUR: hour_next = acc_new[SW-1:0];
                    hdtp_pkg::ROLE_MIN:  min_next  = acc_new[SW-1:0];
                    default:             sec_next  = acc_new[SW-1:0];
                endcase
            end
        end

        mon_idx = hdtp_pkg::month_lookup(mon_next);
        ok = (item.pos >= hdtp_pkg::MIN_LEN - 1'b1) && (fidx_next >= hdtp_pkg::FIELD_COUNT)
             && !err_next && (mon_idx != hdtp_pkg::NO_MONTH);

        result_next.valid_res   = ok;
        result_next.date_format = fmt_next;
        if (ok) begin
            result_next.year = (fmt_next == hdtp_pkg::FMT_850) ?
                               year_next + hdtp_pkg::YEAR_BASE_850 : year_next;
            result_next.month        = mon_idx;
            result_next.day_of_month = day_next;
            result_next.hour         = hour_next;
            result_next.minute       = min_next;
            result_next.second       = sec_next;
        end else begin
            result_next.year         = '0;
            result_next.month        = '0;
            result_next.day_of_month = '0;
            result_next.hour         = '0;
            result_next.minute       = '0;
            result_next.second       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (pop && item.last_byte)) begin
            fmt_reg  <= hdtp_pkg::FMT_1123;
            skip_reg <= 1'b0;
            fidx_reg <= '0;
            dcnt_reg <= '0;
            mon_reg  <= '0;
            day_reg  <= '0;
            year_reg <= '0;
            hour_reg <= '0;
            min_reg  <= '0;
            sec_reg  <= '0;
            err_reg  <= 1'b0;
        end else if (pop) begin
            fmt_reg  <= fmt_next;
            skip_reg <= skip_next;
            fidx_reg <= fidx_next;
            dcnt_reg <= dcnt_next;
            mon_reg  <= mon_next;
            day_reg  <= day_next;
            year_reg <= year_next;
            hour_reg <= hour_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop && item.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && item.last_byte) begin
            out_result_reg <= result_next;
        end
    end

    a_field_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fidx_reg <= hdtp_pkg::FIELD_COUNT)
        else $error("field index past the last field");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dcnt_reg <= 3'd4)
        else $error("byte count within a field too large");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(pop && item.last_byte))
        else $error("result raised without a final byte");

endmodule

// File: rtl/core/http_date_text_parser_top.sv
// m_tvalid is registered: it rises once the back end takes the final byte from the queue.
// Throughput: one byte per cycle while the back end is not held by a waiting result.
// A queue of QUEUE_DEPTH bytes lets input continue while a result waits on m_tready.
// Reset (aresetn low, synchronous) empties the queue, drops any pending result and
// returns the parser to the start of a string; no clearing pass is needed.
module http_date_text_parser_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [13:0] year, [17:14] month, [24:18] day_of_month,
                                   // [31:25] hour, [38:32] minute, [45:39] second, zero pad
    output logic [2:0]  m_tuser    // [0] valid_res, [2:1] date_format
);

    logic                   queue_full;
    logic                   push;
    hdtp_pkg::hdtp_item_t   push_item;
    logic                   pop;
    logic                   queue_valid;
    hdtp_pkg::hdtp_item_t   head_item;
    hdtp_pkg::hdtp_result_t result;

    hdtp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    hdtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_valid),
        .head_item (head_item)
    );

    hdtp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_valid),
        .item       (head_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {2'b00, result.second, result.minute, result.hour,
                      result.day_of_month, result.month, result.year};
    assign m_tuser = {result.date_format, result.valid_res};

endmodule
